@@ sv/i2c_eeprom_byte_access_master_macros.svh @@
// ----------------------------------------------------------------------------
// i2c eeprom byte access master - assertion macros
// Shared concurrent assertion wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH

// checked only outside reset
`define IEBAM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IEBAM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/iebam_pkg.sv @@
// ----------------------------------------------------------------------------
// iebam_pkg
// Types, constants and sequence tables of the eeprom byte access master.
// ----------------------------------------------------------------------------
package iebam_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] DEV_WRITE      = 8'hA0;
  localparam logic [7:0] DEV_READ       = 8'hA1;
  localparam logic [7:0] ACK_WAIT_RESET = 8'd250;

  localparam logic [3:0] WRITE_LEN = 4'd8;
  localparam logic [3:0] READ_LEN  = 4'd10;
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // configuration port
  localparam int         CFG_ADDR_W         = 3;
  localparam logic [2:0] ADDR_ACK_WAIT_LIMIT = 3'd0;

  // front to back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_TICK,
    REQ_WRITE,
    REQ_READ
  } req_t;

  typedef enum logic [2:0] {
    SEG_START,
    SEG_WB_DEVW,
    SEG_WB_ADDR,
    SEG_WB_DATA,
    SEG_WB_DEVR,
    SEG_ACK,
    SEG_RB,
    SEG_STOP
  } seg_t;

  typedef struct packed {
    req_t       kind;
    logic [7:0] word_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
  } res_t;

  // segment of a sequence step, past the end it stays on stop
  function automatic seg_t seg_of(logic [3:0] ph, logic rd);
    seg_t s;
    s = SEG_STOP;
    if (rd) begin
      case (ph)
        4'd1:    s = SEG_START;
        4'd2:    s = SEG_WB_DEVW;
        4'd3:    s = SEG_ACK;
        4'd4:    s = SEG_WB_ADDR;
        4'd5:    s = SEG_ACK;
        4'd6:    s = SEG_START;
        4'd7:    s = SEG_WB_DEVR;
        4'd8:    s = SEG_ACK;
        4'd9:    s = SEG_RB;
        default: s = SEG_STOP;
      endcase
    end else begin
      case (ph)
        4'd1:    s = SEG_START;
        4'd2:    s = SEG_WB_DEVW;
        4'd3:    s = SEG_ACK;
        4'd4:    s = SEG_WB_ADDR;
        4'd5:    s = SEG_ACK;
        4'd6:    s = SEG_WB_DATA;
        4'd7:    s = SEG_ACK;
        default: s = SEG_STOP;
      endcase
    end
    return s;
  endfunction

  // shift register contents on entry to a segment
  function automatic logic [7:0] shift_load(seg_t s, logic [7:0] ha, logic [7:0] hd,
                                            logic [7:0] cur);
    logic [7:0] v;
    v = cur;
    case (s)
      SEG_WB_DEVW: v = DEV_WRITE;
      SEG_WB_ADDR: v = ha;
      SEG_WB_DATA: v = hd;
      SEG_WB_DEVR: v = DEV_READ;
      SEG_RB:      v = 8'd0;
      default:     v = cur;
    endcase
    return v;
  endfunction

endpackage

@@ sv/iebam_front.sv @@
// ----------------------------------------------------------------------------
// iebam_front
// Takes input beats, decodes the op into a request kind, queues them.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_access_master_macros.svh"

module iebam_front
  import iebam_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_word_address,
  input  logic [7:0]  in_write_data,
  input  logic        in_sda,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t             q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  item_t             item_in;

  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = q[rd_ptr];

  always_comb begin
    item_in.word_address = in_word_address;
    item_in.write_data   = in_write_data;
    item_in.sda_in       = in_sda;
    case (in_op)
      OP_WRITE: item_in.kind = REQ_WRITE;
      OP_READ:  item_in.kind = REQ_READ;
      default:  item_in.kind = REQ_TICK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  `IEBAM_ASSERT(a_count_range, count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
  `IEBAM_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "pop from empty queue")
  `IEBAM_ASSERT_RST(a_reset_empty, rst |=> count == '0, "queue not empty after reset")

endmodule

@@ sv/iebam_back.sv @@
// ----------------------------------------------------------------------------
// iebam_back
// Bus sequencer: one pin step per queued tick, result held in an output register.
// ----------------------------------------------------------------------------
`include "i2c_eeprom_byte_access_master_macros.svh"

module iebam_back
  import iebam_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] ack_wait_limit,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output res_t       out_res
);

  logic [3:0] phase, phase_next;
  logic [1:0] sub_step, sub_step_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] ack_count, ack_count_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_data, held_data_next;
  logic       is_read, is_read_next;
  logic [7:0] last_read, last_read_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       done_next;
  logic       seg_end;
  seg_t       seg_cur;
  seg_t       seg_ent;
  res_t       res_next;

  assign q_pop = q_valid && (!out_valid || out_ready);

  // next state of the sequencer for the tick at the queue head
  always_comb begin
    phase_next        = phase;
    sub_step_next     = sub_step;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    ack_count_next    = ack_count;
    held_address_next = held_address;
    held_data_next    = held_data;
    is_read_next      = is_read;
    last_read_next    = last_read;
    scl_next          = scl;
    sda_next          = sda;
    done_next         = 1'b0;
    seg_end           = 1'b0;
    seg_cur           = SEG_START;
    seg_ent           = SEG_START;
    if (q_pop) begin
      if (phase == 4'd0 && (q_item.kind == REQ_WRITE || q_item.kind == REQ_READ)) begin
        held_address_next = q_item.word_address;
        held_data_next    = q_item.write_data;
        is_read_next      = (q_item.kind == REQ_READ);
        phase_next        = 4'd1;
        sub_step_next     = 2'd0;
        bit_count_next    = 4'd0;
        ack_count_next    = 8'd0;
      end
      if (phase_next != 4'd0) begin
        seg_cur = seg_of(phase_next, is_read_next);
        case (seg_cur)
          SEG_START: begin
            case (sub_step_next)
              2'd0:    sda_next = 1'b1;
              2'd1:    scl_next = 1'b1;
              2'd2:    sda_next = 1'b0;
              default: begin
                scl_next = 1'b0;
                seg_end  = 1'b1;
              end
            endcase
            if (!seg_end) begin
              sub_step_next = sub_step_next + 2'd1;
            end
          end
          SEG_ACK: begin
            if (sub_step_next == 2'd0) begin
              scl_next      = 1'b1;
              sub_step_next = 2'd1;
            end else if (q_item.sda_in && ack_count_next < ack_wait_limit) begin
              ack_count_next = ack_count_next + 8'd1;
            end else begin
              scl_next = 1'b0;
              seg_end  = 1'b1;
            end
          end
          SEG_RB: begin
            case (sub_step_next)
              2'd0: begin
                sda_next      = 1'b1;
                sub_step_next = 2'd1;
              end
              2'd1: begin
                scl_next      = 1'b1;
                sub_step_next = 2'd2;
              end
              2'd2: begin
                scl_next        = 1'b0;
                shift_byte_next = {shift_byte_next[6:0], q_item.sda_in};
                bit_count_next  = bit_count_next + 4'd1;
                sub_step_next   = (bit_count_next >= BYTE_BITS) ? 2'd3 : 2'd1;
              end
              default: begin
                sda_next       = 1'b1;
                last_read_next = shift_byte_next;
                seg_end        = 1'b1;
              end
            endcase
          end
          SEG_STOP: begin
            case (sub_step_next)
              2'd0:    sda_next = 1'b0;
              2'd1:    scl_next = 1'b1;
              default: begin
                sda_next = 1'b1;
                seg_end  = 1'b1;
              end
            endcase
            if (!seg_end) begin
              sub_step_next = sub_step_next + 2'd1;
            end
          end
          default: begin
            // byte write, msb first, then release sda for the ack
            if (bit_count_next >= BYTE_BITS) begin
              sda_next = 1'b1;
              seg_end  = 1'b1;
            end else if (sub_step_next == 2'd0) begin
              sda_next      = shift_byte_next[7];
              sub_step_next = 2'd1;
            end else if (sub_step_next == 2'd1) begin
              scl_next      = 1'b1;
              sub_step_next = 2'd2;
            end else begin
              scl_next        = 1'b0;
              shift_byte_next = {shift_byte_next[6:0], 1'b0};
              bit_count_next  = bit_count_next + 4'd1;
              sub_step_next   = 2'd0;
            end
          end
        endcase
        if (seg_end) begin
          if (phase_next >= (is_read_next ? READ_LEN : WRITE_LEN)) begin
            phase_next    = 4'd0;
            sub_step_next = 2'd0;
            done_next     = 1'b1;
          end else begin
            phase_next      = phase_next + 4'd1;
            seg_ent         = seg_of(phase_next, is_read_next);
            sub_step_next   = 2'd0;
            bit_count_next  = 4'd0;
            ack_count_next  = 8'd0;
            shift_byte_next = shift_load(seg_ent, held_address_next, held_data_next,
                                         shift_byte_next);
          end
        end
      end
    end
  end

  // result of the tick
  always_comb begin
    res_next.scl       = scl_next;
    res_next.sda       = sda_next;
    res_next.busy      = (phase_next != 4'd0);
    res_next.done      = done_next;
    res_next.read_data = last_read_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 4'd0;
      sub_step  <= 2'd0;
      bit_count <= 4'd0;
      ack_count <= 8'd0;
      is_read   <= 1'b0;
      last_read <= 8'd0;
      scl       <= 1'b1;
      sda       <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      phase     <= phase_next;
      sub_step  <= sub_step_next;
      bit_count <= bit_count_next;
      ack_count <= ack_count_next;
      is_read   <= is_read_next;
      last_read <= last_read_next;
      scl       <= scl_next;
      sda       <= sda_next;
      if (q_pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_byte   <= shift_byte_next;
    held_address <= held_address_next;
    held_data    <= held_data_next;
    if (q_pop) begin
      out_res <= res_next;
    end
  end

  `IEBAM_ASSERT(a_phase_range, phase <= (is_read ? READ_LEN : WRITE_LEN), "phase past end")
  `IEBAM_ASSERT(a_bit_count_range, bit_count <= BYTE_BITS, "bit count past byte")
  `IEBAM_ASSERT(a_done_idle, q_pop && done_next |=> !out_res.busy && phase == 4'd0, "done busy")
  `IEBAM_ASSERT(a_pop_fills, q_pop |=> out_valid, "popped tick gave no result")

endmodule

@@ sv/i2c_eeprom_byte_access_master.sv @@
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master
// I2C master for a serial eeprom: byte write and random byte read, one pin
// step per input tick.
//
//   channel  dir  beat contents
//   s_axis   in   one bus tick: op in tuser, address, data, sampled sda
//   m_axis   out  one result per tick: pin levels, busy, read byte; tlast = done
//   apb      in   ack_wait_limit at address 0
//
// throughput is one beat per cycle while m_axis is not stalled; an accepted beat
// is registered in the two-entry queue, then in the sequencer's output register.
// a stalled m_axis fills the queue, then s_tready drops.
// rst is synchronous: bus released (scl and sda high), sequencer idle,
// ack_wait_limit back to 250.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master
  import iebam_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [23:0]           s_tdata,   // word_address[7:0], write_data[15:8], sda_in[16]
  input  logic [1:0]            s_tuser,   // op[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // scl_out[0], sda_out[1], busy_res[2], read_data[10:3]
  output logic                  m_tlast,   // done_res
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic [7:0] ack_wait_limit;
  logic       q_valid;
  item_t      q_item;
  logic       q_pop;
  res_t       out_res;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_wait_limit <= ACK_WAIT_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ACK_WAIT_LIMIT) begin
      ack_wait_limit <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr == ADDR_ACK_WAIT_LIMIT) begin
      prdata = {24'd0, ack_wait_limit};
    end
  end

  iebam_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .in_op           (s_tuser),
    .in_word_address (s_tdata[7:0]),
    .in_write_data   (s_tdata[15:8]),
    .in_sda          (s_tdata[16]),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  iebam_back u_back (
    .clk            (clk),
    .rst            (rst),
    .ack_wait_limit (ack_wait_limit),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_res        (out_res)
  );

  assign m_tdata = {5'd0, out_res.read_data, out_res.busy, out_res.sda, out_res.scl};
  assign m_tlast = out_res.done;

endmodule

@@ dv/tb_i2c_eeprom_byte_access_master.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_eeprom_byte_access_master
// Self-checking bench for the eeprom byte access master. A queue of bus ticks
// and register writes feeds a clocked driver. A clocked monitor runs its own
// model of the start / byte / ack / read / stop sequencer on every accepted
// tick and compares each output beat field by field. Both stream sides stall
// at random. The ack wait limit is changed between phases, including 0 and
// 255 and a long no-ack stretch that runs the wait to its end.
// ----------------------------------------------------------------------------
module tb_i2c_eeprom_byte_access_master;
  import iebam_pkg::*;

  localparam logic [1:0] OP_SPARE    = 2'd3;  // unused code, acts as a plain tick
  localparam int         STALL_LIMIT = 1000;
  localparam int         SETTLE      = 4;
  localparam int         TAIL        = 12;

  typedef enum logic [1:0] {ENT_BEAT, ENT_CFG, ENT_DRAIN} ent_kind_t;
  typedef enum logic [1:0] {APB_IDLE, APB_SETUP, APB_ACCESS} apb_st_t;

  typedef struct packed {
    ent_kind_t  kind;
    logic [1:0] op;
    logic [7:0] addr;
    logic [7:0] data;
    logic       sda;
    logic [7:0] limit;
  } pend_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;  // word_address[7:0], write_data[15:8], sda_in[16]
  logic [1:0]  s_tuser = OP_TICK;  // op[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;  // scl_out[0], sda_out[1], busy_res[2], read_data[10:3]
  logic        m_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  i2c_eeprom_byte_access_master DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  pend_t   pend_q[$];
  res_t    pin_levels_q[$];
  int      err_cnt = 0;
  int      ticks_in = 0;
  int      settle_cnt = 0;
  int      stall_cycles = 0;
  apb_st_t apb_st = APB_IDLE;

  // no idling on either side for a while in the middle of the run
  wire steady = (ticks_in >= 250) && (ticks_in < 400);

  // sequencer model state
  logic [7:0] ack_limit;
  logic [3:0] bus_phase;
  logic [3:0] bits_done;
  logic [7:0] shreg;
  logic [7:0] ack_waits;
  logic [7:0] hold_addr;
  logic [7:0] hold_data;
  logic       rd_xfer;
  logic [7:0] last_rd;
  logic [1:0] step_no;
  logic       scl_q;
  logic       sda_q;

  initial begin
    forever #4 clk = ~clk;
  end

  // steps 1..5 are shared, the tails differ between write and read
  function automatic seg_t seg_at(logic [3:0] p, logic rd);
    seg_t s;
    case (p)
      4'd1:       s = SEG_START;
      4'd2:       s = SEG_WB_DEVW;
      4'd3, 4'd5: s = SEG_ACK;
      4'd4:       s = SEG_WB_ADDR;
      4'd6:       s = rd ? SEG_START : SEG_WB_DATA;
      4'd7:       s = rd ? SEG_WB_DEVR : SEG_ACK;
      4'd8:       s = rd ? SEG_ACK : SEG_STOP;
      4'd9:       s = rd ? SEG_RB : SEG_STOP;
      default:    s = SEG_STOP;
    endcase
    return s;
  endfunction

  task automatic enter_seg();
    step_no = 2'd0;
    bits_done = 4'd0;
    ack_waits = 8'd0;
    case (seg_at(bus_phase, rd_xfer))
      SEG_WB_DEVW: shreg = DEV_WRITE;
      SEG_WB_ADDR: shreg = hold_addr;
      SEG_WB_DATA: shreg = hold_data;
      SEG_WB_DEVR: shreg = DEV_READ;
      SEG_RB:      shreg = 8'd0;
      default:     ;
    endcase
  endtask

  task automatic step_bus(input logic [1:0] op, input logic [7:0] wa, input logic [7:0] wd,
                          input logic sdi, output res_t r);
    logic fin;
    fin = 1'b0;
    r = '0;
    if (bus_phase == 4'd0 && (op == OP_WRITE || op == OP_READ)) begin
      hold_addr = wa;
      hold_data = wd;
      rd_xfer = (op == OP_READ);
      bus_phase = 4'd1;
      enter_seg();
    end
    if (bus_phase != 4'd0) begin
      case (seg_at(bus_phase, rd_xfer))
        SEG_START: begin
          case (step_no)
            2'd0:    sda_q = 1'b1;
            2'd1:    scl_q = 1'b1;
            2'd2:    sda_q = 1'b0;
            default: begin
              scl_q = 1'b0;
              fin = 1'b1;
            end
          endcase
          if (!fin) step_no = step_no + 2'd1;
        end
        SEG_ACK: begin
          if (step_no == 2'd0) begin
            scl_q = 1'b1;
            step_no = 2'd1;
          end else if (sdi && ack_waits < ack_limit) begin
            ack_waits = ack_waits + 8'd1;
          end else begin
            scl_q = 1'b0;
            fin = 1'b1;
          end
        end
        SEG_RB: begin
          case (step_no)
            2'd0: begin
              sda_q = 1'b1;
              step_no = 2'd1;
            end
            2'd1: begin
              scl_q = 1'b1;
              step_no = 2'd2;
            end
            2'd2: begin
              // sample on the falling scl tick, msb first
              scl_q = 1'b0;
              shreg = {shreg[6:0], sdi};
              bits_done = bits_done + 4'd1;
              step_no = (bits_done >= BYTE_BITS) ? 2'd3 : 2'd1;
            end
            default: begin
              sda_q = 1'b1;
              last_rd = shreg;
              fin = 1'b1;
            end
          endcase
        end
        SEG_STOP: begin
          case (step_no)
            2'd0:    sda_q = 1'b0;
            2'd1:    scl_q = 1'b1;
            default: begin
              sda_q = 1'b1;
              fin = 1'b1;
            end
          endcase
          if (!fin) step_no = step_no + 2'd1;
        end
        default: begin
          // byte write: data, scl up, scl down per bit, then release sda
          if (bits_done >= BYTE_BITS) begin
            sda_q = 1'b1;
            fin = 1'b1;
          end else if (step_no == 2'd0) begin
            sda_q = shreg[7];
            step_no = 2'd1;
          end else if (step_no == 2'd1) begin
            scl_q = 1'b1;
            step_no = 2'd2;
          end else begin
            scl_q = 1'b0;
            shreg = {shreg[6:0], 1'b0};
            bits_done = bits_done + 4'd1;
            step_no = 2'd0;
          end
        end
      endcase
      if (fin) begin
        if (bus_phase >= (rd_xfer ? READ_LEN : WRITE_LEN)) begin
          bus_phase = 4'd0;
          step_no = 2'd0;
          r.done = 1'b1;
        end else begin
          bus_phase = bus_phase + 4'd1;
          enter_seg();
        end
      end
    end
    r.scl = scl_q;
    r.sda = sda_q;
    r.busy = (bus_phase != 4'd0);
    r.read_data = last_rd;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      err_cnt++;
    end
  endtask

  task automatic queue_tick(input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] data, input logic sda);
    pend_t e;
    e = '0;
    e.kind = ENT_BEAT;
    e.op = op;
    e.addr = addr;
    e.data = data;
    e.sda = sda;
    pend_q.push_back(e);
  endtask

  task automatic queue_ctl(input ent_kind_t kind, input logic [7:0] limit);
    pend_t e;
    e = '0;
    e.kind = kind;
    e.limit = limit;
    pend_q.push_back(e);
  endtask

  // random ticks: requests often enough that a new transfer starts soon after idle
  task automatic queue_random(input int n, input int sda_high_pct);
    int k;
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 30) op = OP_TICK;
      else if (k < 60) op = OP_WRITE;
      else if (k < 90) op = OP_READ;
      else op = OP_SPARE;
      queue_tick(op, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 ($urandom_range(99) < sda_high_pct));
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    pend_t e;
    logic nxt_valid;
    if (rst) begin
      s_tvalid <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      apb_st <= APB_IDLE;
      settle_cnt <= 0;
    end else begin
      case (apb_st)
        APB_SETUP: begin
          penable <= 1'b1;
          apb_st <= APB_ACCESS;
        end
        APB_ACCESS: begin
          if (pready) begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            apb_st <= APB_IDLE;
          end
        end
        default: ;
      endcase
      nxt_valid = s_tvalid && !s_tready;
      if (!s_tvalid || s_tready) begin
        nxt_valid = 1'b0;
        if (apb_st == APB_IDLE && pend_q.size() != 0) begin
          e = pend_q[0];
          if (e.kind == ENT_BEAT) begin
            if (steady || $urandom_range(99) >= 38) begin
              nxt_valid = 1'b1;
              s_tuser <= e.op;
              s_tdata <= {7'd0, e.sda, e.data, e.addr};
              void'(pend_q.pop_front());
            end
          end else if (!s_tvalid && pin_levels_q.size() == 0) begin
            // everything accepted has come back; let the pipeline settle
            if (settle_cnt >= SETTLE) begin
              void'(pend_q.pop_front());
              settle_cnt <= 0;
              if (e.kind == ENT_CFG) begin
                psel <= 1'b1;
                pwrite <= 1'b1;
                paddr <= ADDR_ACK_WAIT_LIMIT;
                pwdata <= {24'd0, e.limit};
                apb_st <= APB_SETUP;
              end
            end else begin
              settle_cnt <= settle_cnt + 1;
            end
          end else begin
            settle_cnt <= 0;
          end
        end
      end
      s_tvalid <= nxt_valid;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      m_tready <= 1'b0;
      ack_limit = ACK_WAIT_RESET;
      bus_phase = 4'd0;
      bits_done = 4'd0;
      shreg = 8'd0;
      ack_waits = 8'd0;
      hold_addr = 8'd0;
      hold_data = 8'd0;
      rd_xfer = 1'b0;
      last_rd = 8'd0;
      step_no = 2'd0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      pin_levels_q.delete();
    end else begin
      m_tready <= steady || ($urandom_range(99) >= 38);
      if (psel && penable && pwrite && pready && paddr == ADDR_ACK_WAIT_LIMIT)
        ack_limit = pwdata[7:0];
      if (s_tvalid && s_tready) begin
        step_bus(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[16], want);
        pin_levels_q.push_back(want);
        ticks_in <= ticks_in + 1;
      end
      if (m_tvalid && m_tready) begin
        if (pin_levels_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual tdata %h tlast %b",
                   $time, m_tdata, m_tlast);
          err_cnt++;
        end else begin
          want = pin_levels_q.pop_front();
          check_field("scl_out", want.scl, m_tdata[0]);
          check_field("sda_out", want.sda, m_tdata[1]);
          check_field("busy_res", want.busy, m_tdata[2]);
          check_field("read_data", want.read_data, m_tdata[10:3]);
          check_field("done_res", want.done, m_tlast);
        end
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // idle ticks, spare op code, then a write with extreme operands
    queue_tick(OP_TICK, 8'h00, 8'h00, 1'b1);
    queue_tick(OP_SPARE, 8'hFF, 8'hFF, 1'b0);
    queue_tick(OP_WRITE, 8'hFF, 8'h00, 1'b1);
    // read request while busy is dropped
    queue_tick(OP_READ, 8'h00, 8'hFF, 1'b0);
    for (int i = 0; i < 8; i++)
      queue_tick(OP_SPARE, 8'h5A, 8'hA5, i[0]);
    // limit change in the middle of a transfer
    queue_ctl(ENT_CFG, 8'd0);
    for (int i = 0; i < 12; i++)
      queue_tick(i[1:0], 8'hFF, 8'hFF, 1'b1);
    queue_random(60, 40);
    queue_ctl(ENT_CFG, 8'd255);
    queue_random(60, 40);
    // no ack for long enough to run the full wait
    for (int i = 0; i < 400; i++)
      queue_tick(OP_READ, 8'($urandom_range(255)), 8'($urandom_range(255)), 1'b1);
    queue_ctl(ENT_CFG, 8'd1);
    queue_random(40, 60);
    queue_ctl(ENT_DRAIN, 8'd0);
    queue_random(40, 60);
    queue_ctl(ENT_CFG, 8'($urandom_range(254, 2)));
    queue_random(50, 30);
    queue_ctl(ENT_CFG, 8'd3);
    queue_random(50, 50);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || s_tvalid || pin_levels_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (pin_levels_q.size() != 0) begin
      $display("%0t: %0d beats still expected, expected 0 actual %0d",
               $time, pin_levels_q.size(), pin_levels_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
